### src/lcar_pkg.sv
`default_nettype none

package lcar_pkg;

   // payload widths fixed by the converter protocol
   localparam int KIND_BITS   = 2;
   localparam int RAW_BITS    = 24;
   localparam int WEIGHT_BITS = 16;
   localparam int TICK_BITS   = 16;
   localparam int RECIP_BITS  = 32;

   // configuration port
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCK_HIGH    = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCALE_RECIP = 1'd1;

   localparam logic [TICK_BITS-1:0]  SCK_HIGH_RESET    = 16'd16;
   localparam logic [RECIP_BITS-1:0] SCALE_RECIP_RESET = 32'd9012627;

   // request kinds
   localparam logic [KIND_BITS-1:0] KIND_PLAIN   = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_TARE    = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_MEASURE = 2'd2;

   // completion codes
   localparam logic [KIND_BITS-1:0] DONE_NONE   = 2'd0;
   localparam logic [KIND_BITS-1:0] DONE_TARE   = 2'd1;
   localparam logic [KIND_BITS-1:0] DONE_WEIGHT = 2'd2;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_WAIT,
      PH_HIGH,
      PH_LOW
   } phase_type;

   typedef struct packed {
      logic                   sck_level;
      logic                   busy_res;
      logic [KIND_BITS-1:0]   done_kind;
      logic [RAW_BITS-1:0]    raw_code;
      logic [WEIGHT_BITS-1:0] weight;
   } result_type;

endpackage

`default_nettype wire

### src/lcar_req_if.sv
`default_nettype none

interface lcar_req_if;

   logic                           valid;
   logic                           ready;
   logic [lcar_pkg::KIND_BITS-1:0] kind;
   logic                           dout_level;

   modport source (output valid, output kind, output dout_level, input ready);
   modport sink   (input valid, input kind, input dout_level, output ready);

endinterface

`default_nettype wire

### src/lcar_rsp_if.sv
`default_nettype none

interface lcar_rsp_if;

   logic                             valid;
   logic                             ready;
   logic                             sck_level;
   logic                             busy_res;
   logic [lcar_pkg::KIND_BITS-1:0]   done_kind;
   logic [lcar_pkg::RAW_BITS-1:0]    raw_code;
   logic [lcar_pkg::WEIGHT_BITS-1:0] weight;

   modport source (
      output valid, output sck_level, output busy_res, output done_kind,
      output raw_code, output weight, input ready
   );
   modport sink (
      input valid, input sck_level, input busy_res, input done_kind,
      input raw_code, input weight, output ready
   );

endinterface

`default_nettype wire

### src/lcar_scaler.sv
`default_nettype none

// scales the assembled code by the Q0.32 reciprocal; the result is held in a
// register and is stable by the final low tick, since a full high phase
// always separates the last data sample from the completing tick
module lcar_scaler #(
   parameter int DATA_BITS = 24
) (
   input  wire logic                                clock,
   input  wire logic                                step,
   input  wire logic [DATA_BITS-1:0]                code,
   input  wire logic [lcar_pkg::RECIP_BITS-1:0]     recip,
   output logic      [lcar_pkg::WEIGHT_BITS-1:0]    scaled
);

   localparam int PROD_BITS = 2 * lcar_pkg::RECIP_BITS;
   localparam int RB        = lcar_pkg::RECIP_BITS;
   localparam int WB        = lcar_pkg::WEIGHT_BITS;

   logic [RB-1:0]        code_ext;
   logic [PROD_BITS-1:0] product;
   logic [WB-1:0]        scaled_in;
   logic [WB-1:0]        scaled_ff;

   // product, integer part, saturate to the weight width
   always_comb begin
      code_ext  = RB'(code);
      product   = code_ext * recip;
      scaled_in = (|product[PROD_BITS-1:RB+WB]) ? {WB{1'b1}} : product[RB+WB-1:RB];
   end

   always_ff @(posedge clock) begin
      if (step) begin
         scaled_ff <= scaled_in;
      end
   end

   assign scaled = scaled_ff;

endmodule

`default_nettype wire

### src/lcar_ctrl.sv
`default_nettype none

// read sequencer: waits for data ready, clocks the code out, applies tare
module lcar_ctrl #(
   parameter int DATA_BITS = 24
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                step,
   input  wire logic [lcar_pkg::KIND_BITS-1:0]      kind,
   input  wire logic                                dout_level,
   input  wire logic [lcar_pkg::TICK_BITS-1:0]      high_ticks,
   input  wire logic [lcar_pkg::WEIGHT_BITS-1:0]    scaled,
   output logic      [DATA_BITS-1:0]                code,
   output lcar_pkg::result_type                     result
);

   localparam int BIT_W = $clog2(DATA_BITS + 1);
   localparam int RAW_W = lcar_pkg::RAW_BITS;
   localparam int WB    = lcar_pkg::WEIGHT_BITS;
   localparam int TB    = lcar_pkg::TICK_BITS;
   localparam int KB    = lcar_pkg::KIND_BITS;

   lcar_pkg::phase_type phase_ff, phase_in;

   logic [KB-1:0]        pending_ff, pending_in;
   logic [BIT_W-1:0]     bit_cnt_ff, bit_cnt_in;
   logic [TB-1:0]        tick_ff, tick_in;
   logic [DATA_BITS-1:0] shift_ff, shift_in;
   logic [WB-1:0]        tare_ff, tare_in;
   logic [WB-1:0]        net_ff, net_in;
   logic [DATA_BITS-1:0] last_code_ff, last_code_in;

   logic [TB-1:0]        tick_inc;
   logic                 bits_done;

   // offset binary view of the assembled code
   assign code      = shift_ff ^ {1'b1, {(DATA_BITS-1){1'b0}}};
   assign bits_done = !(bit_cnt_ff < BIT_W'(DATA_BITS));
   assign tick_inc  = tick_ff + 1'b1;

   // next state
   always_comb begin
      phase_in     = phase_ff;
      pending_in   = pending_ff;
      bit_cnt_in   = bit_cnt_ff;
      tick_in      = tick_ff;
      shift_in     = shift_ff;
      tare_in      = tare_ff;
      net_in       = net_ff;
      last_code_in = last_code_ff;
      unique case (phase_ff)
         lcar_pkg::PH_IDLE: begin
            if (kind == lcar_pkg::KIND_TARE || kind == lcar_pkg::KIND_MEASURE) begin
               pending_in = kind;
               phase_in   = lcar_pkg::PH_WAIT;
            end
         end
         lcar_pkg::PH_WAIT: begin
            if (!dout_level) begin
               phase_in   = lcar_pkg::PH_HIGH;
               tick_in    = '0;
               bit_cnt_in = '0;
               shift_in   = '0;
            end
         end
         lcar_pkg::PH_HIGH: begin
            tick_in = tick_inc;
            if (tick_inc >= high_ticks) begin
               tick_in  = '0;
               phase_in = lcar_pkg::PH_LOW;
            end
         end
         lcar_pkg::PH_LOW: begin
            if (!bits_done) begin
               shift_in   = {shift_ff[DATA_BITS-2:0], dout_level};
               bit_cnt_in = bit_cnt_ff + 1'b1;
               phase_in   = lcar_pkg::PH_HIGH;
            end else begin
               last_code_in = code;
               if (pending_ff == lcar_pkg::KIND_TARE) begin
                  tare_in = scaled;
               end else begin
                  net_in = (scaled >= tare_ff) ? scaled - tare_ff : '0;
               end
               pending_in = lcar_pkg::KIND_PLAIN;
               bit_cnt_in = '0;
               phase_in   = lcar_pkg::PH_IDLE;
            end
         end
         default: begin
            phase_in = lcar_pkg::PH_IDLE;
         end
      endcase
   end

   // outputs for this tick
   always_comb begin
      result.sck_level = (phase_ff == lcar_pkg::PH_HIGH);
      result.busy_res  = (phase_in != lcar_pkg::PH_IDLE);
      result.done_kind = lcar_pkg::DONE_NONE;
      if (phase_ff == lcar_pkg::PH_LOW && bits_done) begin
         result.done_kind = (pending_ff == lcar_pkg::KIND_TARE) ?
                            lcar_pkg::DONE_TARE : lcar_pkg::DONE_WEIGHT;
      end
      result.raw_code = RAW_W'(last_code_in);
      result.weight   = net_in;
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= lcar_pkg::PH_IDLE;
         pending_ff   <= lcar_pkg::KIND_PLAIN;
         bit_cnt_ff   <= '0;
         tick_ff      <= '0;
         shift_ff     <= '0;
         tare_ff      <= '0;
         net_ff       <= '0;
         last_code_ff <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         pending_ff   <= pending_in;
         bit_cnt_ff   <= bit_cnt_in;
         tick_ff      <= tick_in;
         shift_ff     <= shift_in;
         tare_ff      <= tare_in;
         net_ff       <= net_in;
         last_code_ff <= last_code_in;
      end
   end

endmodule

`default_nettype wire

### src/load_cell_adc_reader_tare.sv
// Each accepted request beat is registered, and its response beat follows in the next cycle.
// Throughput: one beat per cycle; the response register frees as it drains,
// so a beat is taken on every cycle in which the response side is not stalled.
// Reset (synchronous): sequencer goes idle, tare and weight clear, config
// registers return to 16 high ticks and the default scale reciprocal.
`default_nettype none

module load_cell_adc_reader_tare #(
   parameter int DATA_BITS = 24
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   lcar_req_if.sink                                   req_bus,
   lcar_rsp_if.source                                 rsp_bus,
   input  wire logic                                  csr_wr_en,
   input  wire logic [lcar_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [lcar_pkg::CSR_DATA_BITS-1:0]    csr_wr_data
);

   localparam int TB = lcar_pkg::TICK_BITS;
   localparam int RB = lcar_pkg::RECIP_BITS;

   logic [TB-1:0] sck_high_ff, sck_high_in;
   logic [RB-1:0] recip_ff, recip_in;
   logic [TB-1:0] high_eff;

   logic                              accept;
   logic [DATA_BITS-1:0]              code;
   logic [lcar_pkg::WEIGHT_BITS-1:0]  scaled;
   lcar_pkg::result_type              result;
   lcar_pkg::result_type              rsp_data_ff;
   logic                              rsp_valid_ff, rsp_valid_in;

   // register writes
   always_comb begin
      sck_high_in = sck_high_ff;
      recip_in    = recip_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            lcar_pkg::CSR_SCK_HIGH:    sck_high_in = csr_wr_data[TB-1:0];
            lcar_pkg::CSR_SCALE_RECIP: recip_in    = csr_wr_data[RB-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sck_high_ff <= lcar_pkg::SCK_HIGH_RESET;
         recip_ff    <= lcar_pkg::SCALE_RECIP_RESET;
      end else begin
         sck_high_ff <= sck_high_in;
         recip_ff    <= recip_in;
      end
   end

   // zero high time behaves as one tick
   assign high_eff = (sck_high_ff == '0) ? TB'(1) : sck_high_ff;

   // beat handshake
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign rsp_valid_in  = accept || (rsp_valid_ff && !rsp_bus.ready);

   lcar_ctrl #(
      .DATA_BITS (DATA_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .step       (accept),
      .kind       (req_bus.kind),
      .dout_level (req_bus.dout_level),
      .high_ticks (high_eff),
      .scaled     (scaled),
      .code       (code),
      .result     (result)
   );

   lcar_scaler #(
      .DATA_BITS (DATA_BITS)
   ) u_scaler (
      .clock  (clock),
      .step   (accept),
      .code   (code),
      .recip  (recip_ff),
      .scaled (scaled)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.sck_level = rsp_data_ff.sck_level;
   assign rsp_bus.busy_res  = rsp_data_ff.busy_res;
   assign rsp_bus.done_kind = rsp_data_ff.done_kind;
   assign rsp_bus.raw_code  = rsp_data_ff.raw_code;
   assign rsp_bus.weight    = rsp_data_ff.weight;

endmodule

`default_nettype wire
